/* hdl/hssm_pkg.sv */
package hssm_pkg;

  localparam logic [16:0] HALF_Q16  = 17'd32768;
  localparam logic [9:0]  FRAME_MAX = 10'd1023;
  localparam logic [3:0]  HANDS_MAX = 4'd15;

  // Top-level sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MSTART,
    ST_MEDIAN,
    ST_READ_EMIT
  } top_state_e;

  // Median selection sequencer.
  typedef enum logic [2:0] {
    MS_IDLE,
    MS_CAND,
    MS_CLAT,
    MS_SCAN,
    MS_EVAL
  } med_state_e;

  // One stored frame: the winning tag per side.
  typedef struct packed {
    logic        lv;
    logic [15:0] ltag;
    logic        rv;
    logic [15:0] rtag;
  } slot_t;

  typedef struct packed {
    logic busy;
    logic done;
  } med_stat_t;

endpackage

/* hdl/hssm_median.sv */
module hssm_median #(
  parameter int unsigned MAX_FRAMES = 64,
  localparam int unsigned AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [16:0]         wr_data_i,
  input  logic                start_i,
  input  logic [CW-1:0]       count_i,
  output hssm_pkg::med_stat_t stat_o,
  output logic [16:0]         median_o
);

  logic [16:0] raw_mem [MAX_FRAMES];
  logic [16:0] rd_q;
  logic [AW-1:0] rd_addr;

  hssm_pkg::med_state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, lt_q, lt_d, le_q, le_d;
  logic          pend_q, pend_d;
  logic [16:0]   cand_q, cand_d, lo_q, lo_d, hi_q, hi_d, med_q, med_d;
  logic          flo_q, flo_d, fhi_q, fhi_d;
  logic [CW-1:0] k_lo, k_hi;
  logic          issue, hit_lo, hit_hi, fin;
  logic [17:0]   sum;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      raw_mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= raw_mem[rd_addr];
  end

  // Ranks of the two middle values; they coincide for an odd count.
  assign k_lo   = (count_i - CW'(1)) >> 1;
  assign k_hi   = count_i >> 1;
  assign issue  = (j_q < count_i);
  assign hit_lo = (lt_q <= k_lo) && (k_lo < le_q);
  assign hit_hi = (lt_q <= k_hi) && (k_hi < le_q);
  assign fin    = (flo_q | hit_lo) && (fhi_q | hit_hi);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hssm_pkg::MS_IDLE: if (start_i) state_d = hssm_pkg::MS_CAND;
      hssm_pkg::MS_CAND: state_d = hssm_pkg::MS_CLAT;
      hssm_pkg::MS_CLAT: state_d = hssm_pkg::MS_SCAN;
      hssm_pkg::MS_SCAN: if (!issue && !pend_q) state_d = hssm_pkg::MS_EVAL;
      hssm_pkg::MS_EVAL: state_d = fin ? hssm_pkg::MS_IDLE : hssm_pkg::MS_CAND;
      default:           state_d = hssm_pkg::MS_IDLE;
    endcase
  end

  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    lt_d    = lt_q;
    le_d    = le_q;
    pend_d  = 1'b0;
    cand_d  = cand_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    flo_d   = flo_q;
    fhi_d   = fhi_q;
    med_d   = med_q;
    rd_addr = i_q[AW-1:0];
    sum     = '0;
    stat_o  = '{busy: (state_q != hssm_pkg::MS_IDLE), done: 1'b0};
    unique case (state_q)
      hssm_pkg::MS_IDLE: begin
        i_d   = '0;
        flo_d = 1'b0;
        fhi_d = 1'b0;
      end
      hssm_pkg::MS_CAND: begin
        rd_addr = i_q[AW-1:0];
      end
      hssm_pkg::MS_CLAT: begin
        cand_d = rd_q;
        j_d    = '0;
        lt_d   = '0;
        le_d   = '0;
      end
      hssm_pkg::MS_SCAN: begin
        // One compare per cycle against the value read the cycle before.
        rd_addr = j_q[AW-1:0];
        pend_d  = issue;
        if (issue) j_d = j_q + CW'(1);
        if (pend_q) begin
          if (rd_q < cand_q)  lt_d = lt_q + CW'(1);
          if (rd_q <= cand_q) le_d = le_q + CW'(1);
        end
      end
      hssm_pkg::MS_EVAL: begin
        if (hit_lo) begin
          lo_d  = cand_q;
          flo_d = 1'b1;
        end
        if (hit_hi) begin
          hi_d  = cand_q;
          fhi_d = 1'b1;
        end
        sum = {1'b0, lo_d} + {1'b0, hi_d};
        if (fin) begin
          med_d       = sum[17:1];
          stat_o.done = 1'b1;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hssm_pkg::MS_IDLE;
      pend_q  <= 1'b0;
      flo_q   <= 1'b0;
      fhi_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      flo_q   <= flo_d;
      fhi_q   <= fhi_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lt_q   <= lt_d;
    le_q   <= le_d;
    cand_q <= cand_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    med_q  <= med_d;
  end

  assign median_o = med_q;

endmodule

/* hdl/hand_slot_selection_median.sv */
// Hand slot selection over one recording.
// Input: one detection transaction is taken on a clock edge where start_i is
// high and busy_o is low. Loading items leave busy_o low, so a new item may
// follow in the very next cycle. The item with recording_end_i set closes the
// recording and raises busy_o. If no frame held more than one hand and at
// least one frame was stored, the median of the first-hand handedness values
// is found by rank counting with a less-than and a less-or-equal compare;
// the handedness memory has one read port, so stored values are read one at
// a time per candidate. Then the stored frames are read back, each in a read
// phase and a result phase, and each result appears for exactly one cycle
// with result_valid_o high; last_result_o marks the final one. A recording
// with no stored frame still gives one result. busy_o falls in the cycle after
// the last result, with the stored-frame, frame and peak-hand counts cleared
// for the next recording. The receiver cannot stall; results are never held
// back. Reset clears the recording counters and the sequencers; the frame
// memories are only read at entries written during the current recording.
module hand_slot_selection_median #(
  parameter int unsigned MAX_FRAMES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        has_detection_i,
  input  logic [16:0] handedness_i,
  input  logic [16:0] confidence_i,
  input  logic [15:0] landmark_tag_i,
  input  logic        frame_end_i,
  input  logic        recording_end_i,
  output logic        result_valid_o,
  output logic        has_left_o,
  output logic        has_right_o,
  output logic [15:0] left_tag_o,
  output logic [15:0] right_tag_o,
  output logic        single_hand_mode_o,
  output logic        has_median_o,
  output logic [16:0] median_handedness_o,
  output logic        stabilized_left_o,
  output logic [9:0]  frames_seen_o,
  output logic [3:0]  most_hands_o,
  output logic        overflow_o,
  output logic        last_result_o
);

  localparam int unsigned AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);

  hssm_pkg::top_state_e state_q, state_d;
  logic          phase_q, phase_d;
  logic [CW-1:0] stored_q, stored_d, k_q, k_d;
  logic [9:0]    frames_q, frames_d;
  logic [3:0]    max_q, max_d, hands_q, hands_d;
  logic          drop_q, drop_d;

  // Working entry of the frame being loaded.
  logic          cur_lv_q, cur_rv_q;
  logic [15:0]   cur_ltag_q, cur_rtag_q;
  logic [16:0]   cur_lconf_q, cur_rconf_q, cur_raw_q;
  logic          lv_n, rv_n;
  logic [15:0]   ltag_n, rtag_n;
  logic [16:0]   lconf_n, rconf_n, raw_n;

  hssm_pkg::slot_t slot_mem [MAX_FRAMES];
  hssm_pkg::slot_t slot_rd_q, slot_wr;

  logic          accept, close, new_frame, room, is_left, upd_l, upd_r, lv_b, rv_b;
  logic          wr_en, single_n, med_start, emit, last;
  logic [3:0]    hands_after;
  logic [CW-1:0] cnt;
  logic          single, hasmed, stab;
  logic [15:0]   one_tag;
  logic [16:0]   median;
  hssm_pkg::med_stat_t med_stat;

  assign accept    = start_i && !busy_o;
  assign close     = frame_end_i || recording_end_i;
  assign new_frame = (hands_q == '0);
  assign room      = (stored_q < CW'(MAX_FRAMES));
  assign is_left   = (handedness_i > hssm_pkg::HALF_Q16);

  always_comb begin
    lv_b        = !new_frame && cur_lv_q;
    rv_b        = !new_frame && cur_rv_q;
    raw_n       = new_frame ? handedness_i : cur_raw_q;
    upd_l       = is_left && (!lv_b || (confidence_i > cur_lconf_q));
    upd_r       = !is_left && (!rv_b || (confidence_i > cur_rconf_q));
    lv_n        = lv_b;
    rv_n        = rv_b;
    ltag_n      = cur_ltag_q;
    rtag_n      = cur_rtag_q;
    lconf_n     = cur_lconf_q;
    rconf_n     = cur_rconf_q;
    hands_after = hands_q;
    if (has_detection_i) begin
      if (upd_l) begin
        lv_n    = 1'b1;
        ltag_n  = landmark_tag_i;
        lconf_n = confidence_i;
      end
      if (upd_r) begin
        rv_n    = 1'b1;
        rtag_n  = landmark_tag_i;
        rconf_n = confidence_i;
      end
      if (hands_q != hssm_pkg::HANDS_MAX) hands_after = hands_q + 4'd1;
    end
  end

  assign slot_wr = '{lv: lv_n, ltag: ltag_n, rv: rv_n, rtag: rtag_n};
  assign wr_en   = accept && close && (hands_after != '0) && room;

  // Next values of the recording counters.
  always_comb begin
    stored_d = stored_q;
    frames_d = frames_q;
    max_d    = max_q;
    hands_d  = hands_q;
    drop_d   = drop_q;
    k_d      = k_q;
    if (accept) begin
      hands_d = hands_after;
      if (close) begin
        if (frames_q != hssm_pkg::FRAME_MAX) frames_d = frames_q + 10'd1;
        if (hands_after > max_q) max_d = hands_after;
        if (hands_after != '0) begin
          if (room) stored_d = stored_q + CW'(1);
          else      drop_d   = 1'b1;
        end
        hands_d = '0;
      end
      k_d = '0;
    end
    if (emit) begin
      k_d = k_q + CW'(1);
      if (last) begin
        stored_d = '0;
        frames_d = '0;
        max_d    = '0;
        drop_d   = 1'b0;
      end
    end
  end

  assign single_n = (max_d <= 4'd1);

  // Next state.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      hssm_pkg::ST_IDLE: begin
        phase_d = 1'b0;
        if (accept && recording_end_i) begin
          state_d = (single_n && (stored_d != '0)) ? hssm_pkg::ST_MSTART
                                                   : hssm_pkg::ST_READ_EMIT;
        end
      end
      hssm_pkg::ST_MSTART: state_d = hssm_pkg::ST_MEDIAN;
      hssm_pkg::ST_MEDIAN: if (med_stat.done) state_d = hssm_pkg::ST_READ_EMIT;
      hssm_pkg::ST_READ_EMIT: begin
        // Phase 0 reads the entry, phase 1 presents the result.
        phase_d = !phase_q;
        if (phase_q && last) state_d = hssm_pkg::ST_IDLE;
      end
      default: state_d = hssm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy_o    = (state_q != hssm_pkg::ST_IDLE);
    med_start = 1'b0;
    emit      = 1'b0;
    unique case (state_q)
      hssm_pkg::ST_MSTART:    med_start = 1'b1;
      hssm_pkg::ST_READ_EMIT: emit      = phase_q;
      default: ;
    endcase
  end

  assign cnt  = (stored_q == '0) ? CW'(1) : stored_q;
  assign last = ((k_q + CW'(1)) == cnt);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[stored_q[AW-1:0]] <= slot_wr;
    end
    slot_rd_q <= slot_mem[k_q[AW-1:0]];
  end

  hssm_median #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(stored_q[AW-1:0]),
    .wr_data_i(raw_n),
    .start_i  (med_start),
    .count_i  (stored_q),
    .stat_o   (med_stat),
    .median_o (median)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hssm_pkg::ST_IDLE;
      phase_q  <= 1'b0;
      stored_q <= '0;
      frames_q <= '0;
      max_q    <= '0;
      hands_q  <= '0;
      drop_q   <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      stored_q <= stored_d;
      frames_q <= frames_d;
      max_q    <= max_d;
      hands_q  <= hands_d;
      drop_q   <= drop_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_detection_i) begin
      cur_lv_q    <= lv_n;
      cur_rv_q    <= rv_n;
      cur_ltag_q  <= ltag_n;
      cur_rtag_q  <= rtag_n;
      cur_lconf_q <= lconf_n;
      cur_rconf_q <= rconf_n;
      cur_raw_q   <= raw_n;
    end
  end

  assign single  = (max_q <= 4'd1);
  assign hasmed  = single && (stored_q != '0);
  assign stab    = hasmed && (median > hssm_pkg::HALF_Q16);
  assign one_tag = slot_rd_q.lv ? slot_rd_q.ltag : slot_rd_q.rtag;

  always_comb begin
    has_left_o  = 1'b0;
    has_right_o = 1'b0;
    left_tag_o  = '0;
    right_tag_o = '0;
    if (stored_q != '0) begin
      if (single) begin
        // Every hand goes to the side picked by the median.
        if (stab) begin
          has_left_o = 1'b1;
          left_tag_o = one_tag;
        end else begin
          has_right_o = 1'b1;
          right_tag_o = one_tag;
        end
      end else begin
        has_left_o  = slot_rd_q.lv;
        left_tag_o  = slot_rd_q.lv ? slot_rd_q.ltag : 16'd0;
        has_right_o = slot_rd_q.rv;
        right_tag_o = slot_rd_q.rv ? slot_rd_q.rtag : 16'd0;
      end
    end
  end

  assign result_valid_o      = emit;
  assign single_hand_mode_o  = single;
  assign has_median_o        = hasmed;
  assign median_handedness_o = hasmed ? median : 17'd0;
  assign stabilized_left_o   = stab;
  assign frames_seen_o       = frames_q;
  assign most_hands_o        = max_q;
  assign overflow_o          = drop_q;
  assign last_result_o       = last;

endmodule

/* hdl/hssm_checker.sv */
module hssm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        recording_end_i,
  input logic        result_valid_o,
  input logic        has_median_o,
  input logic [16:0] median_handedness_o,
  input logic        stabilized_left_o,
  input logic        last_result_o
);

  // Results only come out while the recording is being reported.
  a_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe while idle");

  // Loading items never stall the input.
  a_load_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !recording_end_i) |=> !busy_o)
    else $error("busy after a plain load transaction");

  // Closing the recording starts the report.
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && recording_end_i) |=> busy_o)
    else $error("not busy after recording end");

  // The final result is followed by the return to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |=> (!result_valid_o && !busy_o))
    else $error("activity after the last result");

  a_no_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !has_median_o) |->
      (median_handedness_o == 17'd0 && !stabilized_left_o))
    else $error("median fields set without a median");

endmodule

bind hand_slot_selection_median hssm_checker u_hssm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start_i            (start_i),
  .busy_o             (busy_o),
  .recording_end_i    (recording_end_i),
  .result_valid_o     (result_valid_o),
  .has_median_o       (has_median_o),
  .median_handedness_o(median_handedness_o),
  .stabilized_left_o  (stabilized_left_o),
  .last_result_o      (last_result_o)
);

/* verif/hand_slot_selection_median_tb.sv */
`timescale 1ns / 1ps

module hand_slot_selection_median_tb;

  localparam int FRAME_SLOTS = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 110;

  typedef struct packed {
    logic        left_hit;
    logic        right_hit;
    logic [15:0] left_tag;
    logic [15:0] right_tag;
    logic        single_mode;
    logic        has_median;
    logic [16:0] median;
    logic        stab_left;
    logic [9:0]  frames;
    logic [3:0]  most;
    logic        dropped;
    logic        last;
  } slot_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        has_detection_i = 1'b0;
  logic [16:0] handedness_i = '0;
  logic [16:0] confidence_i = '0;
  logic [15:0] landmark_tag_i = '0;
  logic        frame_end_i = 1'b0;
  logic        recording_end_i = 1'b0;
  logic        busy_o;
  logic        result_valid_o;
  logic        has_left_o;
  logic        has_right_o;
  logic [15:0] left_tag_o;
  logic [15:0] right_tag_o;
  logic        single_hand_mode_o;
  logic        has_median_o;
  logic [16:0] median_handedness_o;
  logic        stabilized_left_o;
  logic [9:0]  frames_seen_o;
  logic [3:0]  most_hands_o;
  logic        overflow_o;
  logic        last_result_o;

  hand_slot_selection_median #(
    .MAX_FRAMES(FRAME_SLOTS)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .has_detection_i     (has_detection_i),
    .handedness_i        (handedness_i),
    .confidence_i        (confidence_i),
    .landmark_tag_i      (landmark_tag_i),
    .frame_end_i         (frame_end_i),
    .recording_end_i     (recording_end_i),
    .result_valid_o      (result_valid_o),
    .has_left_o          (has_left_o),
    .has_right_o         (has_right_o),
    .left_tag_o          (left_tag_o),
    .right_tag_o         (right_tag_o),
    .single_hand_mode_o  (single_hand_mode_o),
    .has_median_o        (has_median_o),
    .median_handedness_o (median_handedness_o),
    .stabilized_left_o   (stabilized_left_o),
    .frames_seen_o       (frames_seen_o),
    .most_hands_o        (most_hands_o),
    .overflow_o          (overflow_o),
    .last_result_o       (last_result_o)
  );

  // Shadow copy of the frame store and counters.
  logic        fr_lv    [FRAME_SLOTS];
  logic        fr_rv    [FRAME_SLOTS];
  logic [15:0] fr_ltag  [FRAME_SLOTS];
  logic [15:0] fr_rtag  [FRAME_SLOTS];
  logic [16:0] fr_lconf [FRAME_SLOTS];
  logic [16:0] fr_rconf [FRAME_SLOTS];
  logic [16:0] fr_first [FRAME_SLOTS];
  int unsigned stored_n = 0;
  int unsigned frame_cnt = 0;
  int unsigned peak_hands = 0;
  int unsigned cur_hands = 0;
  logic        dropped = 1'b0;

  slot_report_t slot_reports_q[$];
  slot_report_t got_rep;
  slot_report_t want_rep;
  int           mismatches = 0;
  int           stall_cycles = 0;
  int           items_sent = 0;
  bit           idle_on = 1'b1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic track_detection(input logic det, input logic [16:0] raw,
                                 input logic [16:0] conf, input logic [15:0] tag,
                                 input logic fe, input logic re);
    int unsigned  s;
    int unsigned  n;
    int unsigned  count;
    int unsigned  sorted [FRAME_SLOTS];
    int unsigned  t;
    int           j;
    logic         single;
    logic         hasmed;
    logic         stab;
    logic [16:0]  med;
    logic [15:0]  one_tag;
    slot_report_t rep;
    s = stored_n;
    if (det) begin
      if (s < FRAME_SLOTS) begin
        if (cur_hands == 0) begin
          fr_lv[s] = 1'b0;
          fr_rv[s] = 1'b0;
          fr_first[s] = raw;
        end
        if (raw > hssm_pkg::HALF_Q16) begin
          if (!fr_lv[s] || conf > fr_lconf[s]) begin
            fr_lv[s] = 1'b1;
            fr_ltag[s] = tag;
            fr_lconf[s] = conf;
          end
        end else begin
          if (!fr_rv[s] || conf > fr_rconf[s]) begin
            fr_rv[s] = 1'b1;
            fr_rtag[s] = tag;
            fr_rconf[s] = conf;
          end
        end
      end
      if (cur_hands < hssm_pkg::HANDS_MAX) cur_hands++;
    end
    if (fe || re) begin
      if (frame_cnt < hssm_pkg::FRAME_MAX) frame_cnt++;
      if (cur_hands > peak_hands) peak_hands = cur_hands;
      if (cur_hands > 0) begin
        if (s < FRAME_SLOTS) stored_n = s + 1;
        else dropped = 1'b1;
      end
      cur_hands = 0;
    end
    if (re) begin
      n = stored_n;
      single = (peak_hands <= 1);
      hasmed = single && (n > 0);
      med = '0;
      if (hasmed) begin
        for (int i = 0; i < n; i++) sorted[i] = fr_first[i];
        for (int i = 1; i < n; i++) begin
          t = sorted[i];
          j = i;
          while (j > 0 && sorted[j - 1] > t) begin
            sorted[j] = sorted[j - 1];
            j--;
          end
          sorted[j] = t;
        end
        if (n % 2 == 1) med = sorted[n / 2];
        else med = (sorted[n / 2 - 1] + sorted[n / 2]) >> 1;
      end
      stab = hasmed && (med > hssm_pkg::HALF_Q16);
      count = (n == 0) ? 1 : n;
      for (int k = 0; k < count; k++) begin
        rep = '0;
        if (n > 0) begin
          if (single) begin
            one_tag = fr_lv[k] ? fr_ltag[k] : fr_rtag[k];
            if (stab) begin
              rep.left_hit = 1'b1;
              rep.left_tag = one_tag;
            end else begin
              rep.right_hit = 1'b1;
              rep.right_tag = one_tag;
            end
          end else begin
            if (fr_lv[k]) begin
              rep.left_hit = 1'b1;
              rep.left_tag = fr_ltag[k];
            end
            if (fr_rv[k]) begin
              rep.right_hit = 1'b1;
              rep.right_tag = fr_rtag[k];
            end
          end
        end
        rep.single_mode = single;
        rep.has_median = hasmed;
        rep.median = med;
        rep.stab_left = stab;
        rep.frames = frame_cnt[9:0];
        rep.most = peak_hands[3:0];
        rep.dropped = dropped;
        rep.last = (k + 1 == count);
        slot_reports_q.insert(slot_reports_q.size(), rep);
      end
      stored_n = 0;
      frame_cnt = 0;
      peak_hands = 0;
      cur_hands = 0;
      dropped = 1'b0;
    end
  endtask

  // Presents one detection and holds it until the block takes the transaction.
  // start_i is left high afterwards so that a back-to-back item needs no toggle.
  task automatic send_item(input logic det, input logic [16:0] raw,
                           input logic [16:0] conf, input logic [15:0] tag,
                           input logic fe, input logic re);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 14) gap = int'($urandom_range(1, 6));
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    has_detection_i <= det;
    handedness_i <= raw;
    confidence_i <= conf;
    landmark_tag_i <= tag;
    frame_end_i <= fe;
    recording_end_i <= re;
    do @(posedge clk_i); while (busy_o);
    track_detection(det, raw, conf, tag, fe, re);
    items_sent++;
  endtask

  task automatic wait_for_reports();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (slot_reports_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Scores lean on the 0.5 boundary and on repeated values, which force ties.
  function automatic logic [16:0] pick_score();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return hssm_pkg::HALF_Q16;
      3: return hssm_pkg::HALF_Q16 + 17'd1;
      4: return 17'($urandom_range(0, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // One recording; multi allows several hands per frame.
  task automatic send_recording(input int n_frames, input bit multi);
    int   hands;
    logic fe;
    logic re;
    for (int f = 0; f < n_frames; f++) begin
      hands = multi ? int'($urandom_range(0, 4)) : int'($urandom_range(0, 5) > 0);
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'b0, 17'($urandom), 17'($urandom), 16'($urandom), 1'b0, 1'b0);
      end
      re = (f == n_frames - 1);
      if (hands == 0) begin
        send_item(1'b0, 17'($urandom), 17'($urandom), 16'($urandom), 1'b1, re);
      end else begin
        for (int h = 0; h < hands; h++) begin
          fe = (h == hands - 1);
          // Sometimes the recording closes without its frame end.
          if (re && fe && $urandom_range(0, 3) == 0) fe = 1'b0;
          send_item(1'b1, pick_score(), pick_score(), 16'($urandom),
                    fe, re && (h == hands - 1));
        end
      end
    end
  endtask

  task automatic test_directed();
    // Empty recording with junk in the ignored hand fields.
    send_item(1'b0, 17'h1FFFF, 17'h1FFFF, 16'hFFFF, 1'b0, 1'b1);
    // Odd single-hand count; the recording end also closes the open frame.
    send_item(1'b1, 17'd0, 17'd0, 16'h0000, 1'b1, 1'b0);
    send_item(1'b1, 17'd65536, 17'd65536, 16'hFFFF, 1'b1, 1'b0);
    send_item(1'b0, 17'd5, 17'd5, 16'h5555, 1'b1, 1'b0);
    send_item(1'b1, hssm_pkg::HALF_Q16, 17'd1, 16'h1234, 1'b0, 1'b1);
    // Even counts: the truncated mean lands just above and at the boundary.
    send_item(1'b1, 17'd32769, 17'd100, 16'hAAAA, 1'b1, 1'b0);
    send_item(1'b1, 17'd32770, 17'd100, 16'h5555, 1'b1, 1'b1);
    send_item(1'b1, 17'd32768, 17'd100, 16'h0F0F, 1'b1, 1'b0);
    send_item(1'b1, 17'd32769, 17'd100, 16'hF0F0, 1'b1, 1'b1);
    // Several hands per frame, confidence ties and out-of-range scores.
    send_item(1'b1, 17'd40000, 17'd500, 16'h0A0A, 1'b0, 1'b0);
    send_item(1'b1, 17'd40001, 17'd500, 16'h0B0B, 1'b0, 1'b0);
    send_item(1'b0, 17'h1FFFF, 17'h1FFFF, 16'hDEAD, 1'b0, 1'b0);
    send_item(1'b1, 17'd100, 17'h1FFFF, 16'h0C0C, 1'b0, 1'b0);
    send_item(1'b1, 17'h1FFFF, 17'h1FFFF, 16'h0D0D, 1'b1, 1'b0);
    send_item(1'b1, hssm_pkg::HALF_Q16, 17'd0, 16'h0E0E, 1'b0, 1'b0);
    send_item(1'b1, hssm_pkg::HALF_Q16, 17'd0, 16'h0F00, 1'b1, 1'b0);
    send_item(1'b1, 17'd65536, 17'd7, 16'h7777, 1'b0, 1'b1);
    wait_for_reports();
  endtask

  task automatic test_hand_saturation();
    for (int h = 0; h < 17; h++) begin
      send_item(1'b1, pick_score(), pick_score(), 16'($urandom), h == 16, h == 16);
    end
  endtask

  // Fills the store and goes past it, once with one hand per frame, once with more.
  task automatic test_storage_full();
    idle_on = 1'b0;
    for (int f = 0; f < 68; f++) begin
      if (f % 30 == 7) begin
        send_item(1'b0, 17'd0, 17'd0, 16'd0, 1'b1, 1'b0);
      end
      send_item(1'b1, pick_score(), pick_score(), 16'($urandom), 1'b1, f == 67);
    end
    wait_for_reports();
    idle_on = 1'b1;
    for (int f = 0; f < 66; f++) begin
      send_item(1'b1, pick_score(), pick_score(), 16'($urandom), 1'b0, 1'b0);
      send_item(1'b1, pick_score(), pick_score(), 16'($urandom), 1'b1, f == 65);
    end
  endtask

  task automatic test_random_recordings();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      send_recording(int'($urandom_range(1, 10)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) wait_for_reports();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_hand_saturation();
    test_storage_full();
    test_random_recordings();
    wait_for_reports();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && slot_reports_q.size() == 0) begin
      $display("hand_slot_selection_median regression: pass");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches,
               slot_reports_q.size());
      $display("hand_slot_selection_median regression: fail");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      got_rep = {has_left_o, has_right_o, left_tag_o, right_tag_o, single_hand_mode_o,
                 has_median_o, median_handedness_o, stabilized_left_o, frames_seen_o,
                 most_hands_o, overflow_o, last_result_o};
      if (slot_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got_rep);
      end else begin
        want_rep = slot_reports_q.pop_front();
        if (got_rep !== want_rep) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"result mismatch: exp L%b/%h R%b/%h single %b med %b/%h stab %b ",
                      "frames %0d most %0d ovf %b last %b"},
                     want_rep.left_hit, want_rep.left_tag, want_rep.right_hit,
                     want_rep.right_tag, want_rep.single_mode, want_rep.has_median,
                     want_rep.median, want_rep.stab_left, want_rep.frames,
                     want_rep.most, want_rep.dropped, want_rep.last);
            $display({"                 got L%b/%h R%b/%h single %b med %b/%h stab %b ",
                      "frames %0d most %0d ovf %b last %b"},
                     got_rep.left_hit, got_rep.left_tag, got_rep.right_hit,
                     got_rep.right_tag, got_rep.single_mode, got_rep.has_median,
                     got_rep.median, got_rep.stab_left, got_rep.frames,
                     got_rep.most, got_rep.dropped, got_rep.last);
          end
        end
      end
    end
  end

  // Any accepted transaction on either side restarts the count.
  initial begin
    forever begin
      @(posedge clk_i);
      if ((start_i && busy_o === 1'b0) || result_valid_o === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", stall_cycles);
        $display("hand_slot_selection_median regression: fail");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
hdl/hssm_pkg.sv
hdl/hssm_median.sv
hdl/hand_slot_selection_median.sv
hdl/hssm_checker.sv
verif/hand_slot_selection_median_tb.sv
